### hw/rtl/ldik_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldik_pkg
// shared constants and types for the linear delta inverse kinematics block
// ----------------------------------------------------------------------------
package ldik_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int POS_W = 32;
	localparam int REG_W = 31;
	localparam int TRIG_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_BASE_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EFF_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COS_ALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_ALPHA = 3'd4;

	// leg unit vectors, signed Q1.16
	localparam logic signed [TRIG_W-1:0] LEG_COS [3] = '{18'sd65536, -18'sd32768, -18'sd32768};
	localparam logic signed [TRIG_W-1:0] LEG_SIN [3] = '{18'sd0, 18'sd56756, -18'sd56756};

	// widths of intermediates
	localparam int L_W = 34;   // leg vector component
	localparam int D_W = 19;   // rail direction component
	localparam int P_W = 36;   // projection p
	localparam int SQ_W = 72;  // squares and root argument
	localparam int RT_W = 36;  // root

	// root bits resolved per square root stage, must divide RT_W
	localparam int SQRT_STEP = 4;

	// per-leg geometry handed from the front end to the root stages
	typedef struct packed {
		logic signed [P_W-1:0] p;
		logic [SQ_W-1:0] arg;
		logic neg;
	} leg_geo_t;

endpackage

### hw/rtl/ldik_leg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldik_leg_front
// forms leg vector, projection on the rail and the root argument for one leg
// ----------------------------------------------------------------------------
module ldik_leg_front #(
	parameter int LEG = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  logic signed [ldik_pkg::POS_W-1:0] target_x,
	input  logic signed [ldik_pkg::POS_W-1:0] target_y,
	input  logic signed [ldik_pkg::POS_W-1:0] target_z,
	input  logic signed [ldik_pkg::REG_W:0] offset,
	input  logic signed [ldik_pkg::TRIG_W-1:0] cos_alpha,
	input  logic signed [ldik_pkg::TRIG_W-1:0] sin_alpha,
	input  logic [ldik_pkg::SQ_W-1:0] l2,
	output logic vld_out,
	output ldik_pkg::leg_geo_t geo
);
	import ldik_pkg::*;

	localparam logic signed [TRIG_W-1:0] LC = LEG_COS[LEG];
	localparam logic signed [TRIG_W-1:0] LS = LEG_SIN[LEG];

	// stage 1: offsets, direction, leg vector
	logic signed [50:0] ox_m, oy_m;
	logic signed [36:0] dx_m, dy_m;
	logic signed [L_W-1:0] lx_s1, ly_s1, lz_s1;
	logic signed [D_W-1:0] dx_s1, dy_s1, dz_s1;
	logic vld_s1;

	// stage 2: products and squares
	logic signed [54:0] px_s2, py_s2, pz_s2;
	logic [SQ_W-1:0] ll_s2;
	logic [SQ_W-1:0] l2_s2;
	logic vld_s2;

	// stage 3: projection
	logic signed [56:0] psum;
	logic signed [P_W-1:0] p_s3;
	logic [SQ_W-1:0] ll_s3, l2_s3;
	logic vld_s3;

	// stage 4: root argument
	logic [SQ_W:0] s_full;
	logic [SQ_W-1:0] pmag;

	assign ox_m = 51'(offset) * 51'(LC) + 51'sd32768;
	assign oy_m = 51'(offset) * 51'(LS) + 51'sd32768;
	assign dx_m = 37'(cos_alpha) * 37'(LC) + 37'sd32768;
	assign dy_m = 37'(cos_alpha) * 37'(LS) + 37'sd32768;

	assign psum = 57'(px_s2) + 57'(py_s2) + 57'(pz_s2) + 57'sd32768;
	assign pmag = SQ_W'(p_s3) * SQ_W'(p_s3);
	assign s_full = {1'b0, pmag} + {1'b0, l2_s3} - {1'b0, ll_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_out <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		lx_s1 <= L_W'(target_x) + L_W'(ox_m >>> 16);
		ly_s1 <= L_W'(target_y) + L_W'(oy_m >>> 16);
		lz_s1 <= L_W'(target_z);
		dx_s1 <= -D_W'(dx_m >>> 16);
		dy_s1 <= -D_W'(dy_m >>> 16);
		dz_s1 <= -D_W'(sin_alpha);

		px_s2 <= 55'(dx_s1) * 55'(lx_s1);
		py_s2 <= 55'(dy_s1) * 55'(ly_s1);
		pz_s2 <= 55'(dz_s1) * 55'(lz_s1);
		ll_s2 <= SQ_W'(lx_s1) * SQ_W'(lx_s1) + SQ_W'(ly_s1) * SQ_W'(ly_s1)
			+ SQ_W'(lz_s1) * SQ_W'(lz_s1);
		l2_s2 <= l2;

		p_s3 <= P_W'(psum >>> 16);
		ll_s3 <= ll_s2;
		l2_s3 <= l2_s2;

		geo.p <= p_s3;
		geo.neg <= s_full[SQ_W];
		geo.arg <= s_full[SQ_W-1:0];
	end

endmodule

### hw/rtl/ldik_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldik_sqrt_pipe
// pipelined restoring floor square root, carriage difference and saturation
// ----------------------------------------------------------------------------
module ldik_sqrt_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_in,
	input  ldik_pkg::leg_geo_t geo,
	output logic vld_out,
	output logic signed [ldik_pkg::POS_W-1:0] pos,
	output logic unreach
);
	import ldik_pkg::*;

	localparam int NST = RT_W / SQRT_STEP;

	logic [SQ_W-1:0] rem_q [NST+1];
	logic [SQ_W-1:0] num_q [NST+1];
	logic [RT_W-1:0] root_q [NST+1];
	logic signed [P_W-1:0] p_q [NST+1];
	logic neg_q [NST+1];
	logic vld_q [NST+1];

	always_comb begin
		rem_q[0] = '0;
		num_q[0] = geo.neg ? '0 : geo.arg;
		root_q[0] = '0;
		p_q[0] = geo.p;
		neg_q[0] = geo.neg;
		vld_q[0] = vld_in;
	end

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic [SQ_W-1:0] r, n;
		logic [RT_W-1:0] q;
		logic [SQ_W+1:0] t;
		always_comb begin
			r = rem_q[g];
			n = num_q[g];
			q = root_q[g];
			t = '0;
			for (int k = 0; k < SQRT_STEP; k++) begin
				r = {r[SQ_W-3:0], n[SQ_W-1:SQ_W-2]};
				n = {n[SQ_W-3:0], 2'b00};
				t = {2'b00, r} - {2'b00, SQ_W'({q, 2'b01})};
				if (!t[SQ_W+1]) begin
					r = t[SQ_W-1:0];
					q = {q[RT_W-2:0], 1'b1};
				end else begin
					q = {q[RT_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else begin
				vld_q[g+1] <= vld_q[g];
			end
		end
		always_ff @(posedge clk) begin
			rem_q[g+1] <= r;
			num_q[g+1] <= n;
			root_q[g+1] <= q;
			p_q[g+1] <= p_q[g];
			neg_q[g+1] <= neg_q[g];
		end
	end

	logic signed [P_W:0] diff;
	assign diff = (P_W+1)'(p_q[NST]) - (P_W+1)'({1'b0, root_q[NST]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_q[NST];
		end
	end

	always_ff @(posedge clk) begin
		unreach <= neg_q[NST];
		if (diff > (P_W+1)'(32'sh7fffffff)) begin
			pos <= 32'sh7fffffff;
		end else if (diff < -(P_W+1)'(33'sh080000000)) begin
			pos <= 32'sh80000000;
		end else begin
			pos <= diff[POS_W-1:0];
		end
	end

endmodule

### hw/rtl/linear_delta_inverse_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_delta_inverse_kinematics
// three-leg linear delta inverse kinematics, one setpoint per clock
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// command   in         start & !busy       target_x/y/z
// result    out        done (one cycle)    carriage_pos_0..2, unreachable_mask
// config    in         cfg_valid&cfg_ready cfg_index, cfg_data
//
// a setpoint enters every cycle and passes through 4 geometry stages,
// 9 root stages (4 bits each) and the saturating output register before
// its result appears
// busy is never raised and cfg_ready is always high: the receiver cannot stall
// arst_n clears the valid pipeline and loads the register defaults
// ----------------------------------------------------------------------------
module linear_delta_inverse_kinematics #(
	parameter int FRAC_BITS = ldik_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [ldik_pkg::POS_W-1:0] target_x,
	input  logic signed [ldik_pkg::POS_W-1:0] target_y,
	input  logic signed [ldik_pkg::POS_W-1:0] target_z,
	output logic done,
	output logic signed [ldik_pkg::POS_W-1:0] carriage_pos_0,
	output logic signed [ldik_pkg::POS_W-1:0] carriage_pos_1,
	output logic signed [ldik_pkg::POS_W-1:0] carriage_pos_2,
	output logic [2:0] unreachable_mask,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ldik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ldik_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ldik_pkg::*;

	// the math is scale free: FRAC_BITS only sets the reset values of lengths
	localparam logic [REG_W-1:0] BASE_RST = REG_W'(100 << FRAC_BITS);
	localparam logic [REG_W-1:0] EFF_RST = REG_W'(50 << FRAC_BITS);
	localparam logic [REG_W-1:0] ARM_RST = REG_W'(200 << FRAC_BITS);

	logic [REG_W-1:0] base_q, eff_q, arm_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic signed [REG_W:0] offset;
	logic [SQ_W-1:0] l2;
	logic accept;
	logic [2:0] vld_geo, vld_res;
	leg_geo_t geo [3];
	logic signed [POS_W-1:0] pos [3];
	logic [2:0] unr;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start & ~busy;

	// configuration registers, to be written only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			eff_q <= EFF_RST;
			arm_q <= ARM_RST;
			cos_q <= '0;
			sin_q <= TRIG_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_RADIUS: base_q <= cfg_data[REG_W-1:0];
				REG_EFF_RADIUS: eff_q <= cfg_data[REG_W-1:0];
				REG_ARM_LENGTH: arm_q <= cfg_data[REG_W-1:0];
				REG_COS_ALPHA: cos_q <= cfg_data[TRIG_W-1:0];
				REG_SIN_ALPHA: sin_q <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	// derived from config registers, which the user must keep stable while items are in flight; not enforced
	assign offset = $signed({1'b0, eff_q}) - $signed({1'b0, base_q});
	assign l2 = SQ_W'(arm_q) * SQ_W'(arm_q);

	for (genvar i = 0; i < 3; i++) begin : g_leg
		ldik_leg_front #(.LEG(i)) u_front (
			.clk(clk), .arst_n(arst_n), .vld_in(accept),
			.target_x(target_x), .target_y(target_y), .target_z(target_z),
			.offset(offset), .cos_alpha(cos_q), .sin_alpha(sin_q), .l2(l2),
			.vld_out(vld_geo[i]), .geo(geo[i])
		);
		ldik_sqrt_pipe u_sqrt (
			.clk(clk), .arst_n(arst_n), .vld_in(vld_geo[i]), .geo(geo[i]),
			.vld_out(vld_res[i]), .pos(pos[i]), .unreach(unr[i])
		);
	end

	// all legs run in lockstep, the AND of the three leg valids marks the beat
	assign done = vld_res[0] & vld_res[1] & vld_res[2];
	assign carriage_pos_0 = pos[0];
	assign carriage_pos_1 = pos[1];
	assign carriage_pos_2 = pos[2];
	assign unreachable_mask = unr;

endmodule
